### hdl/bfsd_pkg.sv
package bfsd_pkg;

    // key schedule seed and byte mixing multiplier
    localparam logic [31:0] SEED_WORD   = 32'hCAFFE19E;
    localparam logic [31:0] MIX_MULT    = 32'h0F902007;
    localparam int          KEY_LEN_DEF = 8;
    localparam int          KEY_W       = 64;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY_SQ,
        ST_KEY_MIX,
        ST_KEY_WORD,
        ST_DAT_SQ,
        ST_DAT_MIX,
        ST_DAT_WORD
    } state_t;

    // shared multiplier operations
    typedef enum logic [1:0] {
        MUL_SQ,
        MUL_MIX,
        MUL_WORD
    } mul_op_t;

    // controller to datapath commands
    typedef struct packed {
        logic    in_ready;
        logic    load_in;
        logic    seed;
        logic    key_src;
        logic    key_cnt_clr;
        logic    key_cnt_inc;
        logic    latch_m;
        mul_op_t op;
        logic    word_upd;
        logic    push_out;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic fresh;
        logic key_last;
        logic out_stall;
    } status_t;

endpackage

### hdl/bfsd_if.sv
interface bfsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] cipher_byte;
    logic       last_in_record;

    modport source (output valid, cipher_byte, last_in_record, input ready);
    modport sink (input valid, cipher_byte, last_in_record, output ready);
endinterface

interface bfsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] plain_byte;
    logic       last_out;

    modport source (output valid, plain_byte, last_out, input ready);
    modport sink (input valid, plain_byte, last_out, output ready);
endinterface

interface bfsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] key_bytes;

    modport source (output valid, key_bytes, input ready);
    modport sink (input valid, key_bytes, output ready);
endinterface

### hdl/byte_feedback_stream_decipher.sv
// Byte feedback stream decipher.
// din takes one transaction per ciphertext byte (cipher_byte, last_in_record);
// dout gives one transaction per byte (plain_byte, last_out) in the same order.
// cfg writes the 64-bit key_bytes register; its ready is always high. Write it
// only while no byte is in flight; a new key is used from the next record start.
// A byte inside a record passes through idle and three work states (DAT_SQ,
// DAT_MIX, DAT_WORD); din is ready only in idle, so it takes no new byte
// until the last one has left DAT_WORD. The first byte of a record first runs
// the key schedule, three steps (KEY_SQ, KEY_MIX, KEY_WORD) per key byte. Every
// feedback step uses the one shared 32x32 multiplier three times: byte squared,
// times the mixing constant, word product. A result waits in the dout register
// while the receiver stalls; the next byte is still accepted and holds in its
// last work state until that register frees. Reset clears the key to zero, the
// feedback words to zero and marks the next byte as a record start.
module byte_feedback_stream_decipher #(
    parameter int KEY_LEN = bfsd_pkg::KEY_LEN_DEF
) (
    input logic      clk,
    input logic      rst_n,
    bfsd_in_if.sink  din,
    bfsd_out_if.source dout,
    bfsd_cfg_if.sink cfg
);
    import bfsd_pkg::*;

    cmd_t    cmd;
    status_t st;

    assign cfg.ready = 1'b1;
    assign din.ready = cmd.in_ready;

    // sequencer
    bfsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .st       (st),
        .cmd      (cmd)
    );

    // feedback words, multiplier and output register
    bfsd_dp #(
        .KEY_LEN (KEY_LEN)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .cipher_byte    (din.cipher_byte),
        .last_in_record (din.last_in_record),
        .cfg_valid      (cfg.valid),
        .key_bytes      (cfg.key_bytes),
        .out_valid      (dout.valid),
        .out_ready      (dout.ready),
        .plain_byte     (dout.plain_byte),
        .last_out       (dout.last_out)
    );
endmodule

### hdl/bfsd_ctrl.sv
module bfsd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  bfsd_pkg::status_t st,
    output bfsd_pkg::cmd_t    cmd
);
    import bfsd_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = st.fresh ? ST_KEY_SQ : ST_DAT_SQ;
                end
            end
            ST_KEY_SQ:   state_next = ST_KEY_MIX;
            ST_KEY_MIX:  state_next = ST_KEY_WORD;
            ST_KEY_WORD: state_next = st.key_last ? ST_DAT_SQ : ST_KEY_SQ;
            ST_DAT_SQ:   state_next = ST_DAT_MIX;
            ST_DAT_MIX:  state_next = ST_DAT_WORD;
            ST_DAT_WORD:
            begin
                if (!st.out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd = '0;
        cmd.op = MUL_SQ;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready    = 1'b1;
                cmd.load_in     = in_valid;
                cmd.seed        = in_valid & st.fresh;
                cmd.key_cnt_clr = in_valid & st.fresh;
            end
            ST_KEY_SQ:
            begin
                cmd.key_src = 1'b1;
                cmd.op      = MUL_SQ;
            end
            ST_KEY_MIX:
            begin
                cmd.op = MUL_MIX;
            end
            ST_KEY_WORD:
            begin
                cmd.op          = MUL_WORD;
                cmd.word_upd    = 1'b1;
                cmd.key_cnt_inc = 1'b1;
            end
            ST_DAT_SQ:
            begin
                cmd.op      = MUL_SQ;
                cmd.latch_m = 1'b1;
            end
            ST_DAT_MIX:
            begin
                cmd.op = MUL_MIX;
            end
            ST_DAT_WORD:
            begin
                cmd.op       = MUL_WORD;
                cmd.word_upd = ~st.out_stall;
                cmd.push_out = ~st.out_stall;
            end
            default:
            begin
                cmd.op = MUL_SQ;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a fresh record always starts with the key schedule
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && st.fresh) |=> state_reg == ST_KEY_SQ)
        else $error("fresh record skipped key schedule");

    // last key step hands over to the data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KEY_WORD && st.key_last) |=> state_reg == ST_DAT_SQ)
        else $error("key schedule did not end at last key byte");
`endif
endmodule

### hdl/bfsd_dp.sv
module bfsd_dp #(
    parameter int KEY_LEN = bfsd_pkg::KEY_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bfsd_pkg::cmd_t              cmd,
    output bfsd_pkg::status_t           st,
    input  logic [7:0]                  cipher_byte,
    input  logic                        last_in_record,
    input  logic                        cfg_valid,
    input  logic [bfsd_pkg::KEY_W-1:0]  key_bytes,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  plain_byte,
    output logic                        last_out
);
    import bfsd_pkg::*;

    localparam int KCNT_W = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;

    logic [KEY_W-1:0]  key_reg;
    logic [KCNT_W-1:0] key_cnt_reg;
    logic [31:0]       word_now_reg;
    logic [31:0]       word_before_reg;
    logic              fresh_reg;
    logic [7:0]        c_reg;
    logic              last_reg;
    logic [7:0]        m_reg;
    logic [15:0]       sq_reg;
    logic [31:0]       mix_reg;
    logic              out_valid_reg;
    logic [7:0]        plain_reg;
    logic              last_out_reg;

    logic [7:0]  key_byte;
    logic [7:0]  m_now;
    logic [7:0]  sq_byte;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_prod;

    // key register, written from the configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_valid)
        begin
            key_reg <= key_bytes;
        end
    end

    // key byte counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_cnt_reg <= '0;
        end
        else if (cmd.key_cnt_clr)
        begin
            key_cnt_reg <= '0;
        end
        else if (cmd.key_cnt_inc)
        begin
            key_cnt_reg <= key_cnt_reg + KCNT_W'(1);
        end
    end

    assign key_byte = key_reg[8*key_cnt_reg +: 8];

    // plaintext byte from the current feedback words
    assign m_now = c_reg ^ word_now_reg[10:3] ^ {word_before_reg[4:0], 3'b000};
    assign sq_byte = cmd.key_src ? key_byte : m_now;

    // shared multiplier, low 32 bits of the product
    always_comb
    begin
        case (cmd.op)
            MUL_SQ:
            begin
                mul_a = {24'd0, sq_byte};
                mul_b = {24'd0, sq_byte};
            end
            MUL_MIX:
            begin
                mul_a = {16'd0, sq_reg};
                mul_b = MIX_MULT;
            end
            MUL_WORD:
            begin
                mul_a = {2'b00, word_now_reg[31:2]};
                mul_b = {7'd0, word_now_reg[31:7]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // multiplier result registers and input transaction capture
    always_ff @(posedge clk)
    begin
        if (cmd.op == MUL_SQ)
        begin
            sq_reg <= mul_prod[15:0];
        end
        if (cmd.op == MUL_MIX)
        begin
            mix_reg <= mul_prod;
        end
        if (cmd.latch_m)
        begin
            m_reg <= m_now;
        end
        if (cmd.load_in)
        begin
            c_reg    <= cipher_byte;
            last_reg <= last_in_record;
        end
    end

    // feedback words and record start flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_now_reg    <= '0;
            word_before_reg <= '0;
            fresh_reg       <= 1'b1;
        end
        else
        begin
            if (cmd.seed)
            begin
                word_now_reg <= SEED_WORD;
            end
            else if (cmd.word_upd)
            begin
                word_now_reg    <= mul_prod ^ mix_reg;
                word_before_reg <= word_now_reg;
            end
            if (cmd.push_out)
            begin
                fresh_reg <= last_reg;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_out)
        begin
            plain_reg    <= m_reg;
            last_out_reg <= last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign plain_byte = plain_reg;
    assign last_out   = last_out_reg;

    assign st.fresh     = fresh_reg;
    assign st.key_last  = (key_cnt_reg == KCNT_W'(KEY_LEN - 1));
    assign st.out_stall = out_valid_reg & ~out_ready;

`ifndef SYNTHESIS
    // never overwrite a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_out |-> !(out_valid_reg && !out_ready))
        else $error("result pushed over a stalled result");

    // words only move when the multiplier is on the word product
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.word_upd |-> cmd.op == MUL_WORD)
        else $error("word update without word product");
`endif
endmodule

### verif/testbench.sv
module testbench;
    import bfsd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [7:0] plain;
        logic       last;
    } plain_rec_t;

    logic clk;
    logic rst_n;

    bfsd_in_if  cipher_ch ();
    bfsd_out_if plain_ch ();
    bfsd_cfg_if key_ch ();

    byte_feedback_stream_decipher DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (cipher_ch),
        .dout  (plain_ch),
        .cfg   (key_ch)
    );

    // mirror of the decipher state
    logic [31:0] fb_now;
    logic [31:0] fb_prev;
    logic        at_record_start;
    logic [63:0] key_shadow;

    plain_rec_t plain_q[$];
    int         fail_count;
    int         cycle_count;
    int         hold_len;
    bit         calm;

    // clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // one feedback step, products wrap at 32 bits
    function automatic logic [31:0] feedback_step(input logic [31:0] w, input logic [7:0] b);
        logic [31:0] bw;
        bw = {24'd0, b};
        return ((w >> 2) * (w >> 7)) ^ (bw * bw * MIX_MULT);
    endfunction

    // predict the plaintext byte of one accepted ciphertext byte
    task automatic decipher_byte(input logic [7:0] c, input logic last);
        logic [31:0] m32;
        plain_rec_t  rec;
        if (at_record_start)
        begin
            fb_now = SEED_WORD;
            for (int i = 0; i < KEY_LEN_DEF; i++)
            begin
                fb_prev = fb_now;
                fb_now  = feedback_step(fb_now, key_shadow[8*i +: 8]);
            end
        end
        m32 = {24'd0, c} ^ (fb_now >> 3) ^ (fb_prev << 3);
        fb_prev = fb_now;
        fb_now  = feedback_step(fb_now, m32[7:0]);
        at_record_start = last;
        rec.plain = m32[7:0];
        rec.last  = last;
        plain_q.push_back(rec);
    endtask

    // send one ciphertext transaction, called and returning at a rising edge
    task automatic send_byte(input logic [7:0] c, input logic last);
        while (!calm && $urandom_range(99) < 17)
        begin
            cipher_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cipher_ch.valid          <= 1'b1;
        cipher_ch.cipher_byte    <= c;
        cipher_ch.last_in_record <= last;
        do
            @(negedge clk);
        while (!cipher_ch.ready);
        @(posedge clk);
        decipher_byte(c, last);
    endtask

    // stop sending and wait until every expected byte has come out
    task automatic wait_idle();
        cipher_ch.valid <= 1'b0;
        while (plain_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // key register write, only while idle
    task automatic write_key(input logic [63:0] k);
        key_ch.valid     <= 1'b1;
        key_ch.key_bytes <= k;
        do
            @(negedge clk);
        while (!key_ch.ready);
        @(posedge clk);
        key_ch.valid <= 1'b0;
        key_shadow = k;
    endtask

    // decipher with the key left at zero by reset
    task automatic test_reset_key();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        wait_idle();
    endtask

    // all-ones key, then a mixed key, with extreme byte values
    task automatic test_key_extremes();
        write_key(64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        wait_idle();
        write_key(64'h0123_4567_89AB_CDEF);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        wait_idle();
    endtask

    // a new key inside a record waits for the next record start
    task automatic test_key_mid_record();
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b0);
        wait_idle();
        write_key(64'hFEDC_BA98_7654_3210);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h81, 1'b1);
        send_byte(8'h42, 1'b1);
        wait_idle();
    endtask

    // one-byte records, each one reruns the key schedule
    task automatic test_single_byte_records();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h96, 1'b1);
        wait_idle();
    endtask

    // receiver holds off while the sender keeps offering bytes
    task automatic test_backpressure();
        hold_len = 150;
        calm = 1'b1;
        for (int i = 0; i < 30; i++)
            send_byte(8'($urandom_range(255)), ($urandom_range(3) == 0));
        calm = 1'b0;
        wait_idle();
    endtask

    // random records of random bytes over several keys
    task automatic test_random_records(input int n_items);
        int          sent;
        int          rec_len;
        int          next_key_at;
        int          key_pick;
        logic [63:0] k;
        sent = 0;
        next_key_at = 0;
        key_pick = 0;
        while (sent < n_items)
        begin
            calm = (sent >= 200 && sent < 350);
            if (sent >= next_key_at)
            begin
                wait_idle();
                case (key_pick % 4)
                    0: k = 64'd0;
                    1: k = 64'hFFFF_FFFF_FFFF_FFFF;
                    default: k = {$urandom, $urandom};
                endcase
                write_key(k);
                key_pick++;
                next_key_at += 120;
            end
            rec_len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
            for (int i = 0; i < rec_len; i++)
            begin
                send_byte(8'($urandom_range(255)), (i == rec_len - 1));
                sent++;
            end
        end
        calm = 1'b0;
        wait_idle();
    endtask

    // receiver ready, with random stalls and one long hold-off
    initial
    begin
        plain_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                plain_ch.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            else
                plain_ch.ready <= calm || ($urandom_range(99) >= 17);
        end
    end

    // check each accepted plaintext transaction against the oldest prediction
    always @(negedge clk)
    begin
        plain_rec_t want;
        if (rst_n && plain_ch.valid && plain_ch.ready)
        begin
            if (plain_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected byte: plain_byte=%h last_out=%b",
                             plain_ch.plain_byte, plain_ch.last_out);
            end
            else
            begin
                want = plain_q.pop_front();
                if (plain_ch.plain_byte !== want.plain || plain_ch.last_out !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: plain_byte exp %h got %h, last_out exp %b got %b",
                                 want.plain, plain_ch.plain_byte, want.last, plain_ch.last_out);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        rst_n = 1'b0;
        cipher_ch.valid = 1'b0;
        cipher_ch.cipher_byte = 8'd0;
        cipher_ch.last_in_record = 1'b0;
        key_ch.valid = 1'b0;
        key_ch.key_bytes = 64'd0;
        fb_now = 32'd0;
        fb_prev = 32'd0;
        at_record_start = 1'b1;
        key_shadow = 64'd0;
        fail_count = 0;
        cycle_count = 0;
        hold_len = 0;
        calm = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_key();
        test_key_extremes();
        test_key_mid_record();
        test_single_byte_records();
        test_backpressure();
        test_random_records(600);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && plain_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

### byte_feedback_stream_decipher.f
hdl/bfsd_pkg.sv
hdl/bfsd_if.sv
hdl/bfsd_ctrl.sv
hdl/bfsd_dp.sv
hdl/byte_feedback_stream_decipher.sv
verif/testbench.sv
